// ===== hdl/imu_angle_frame_parser_core_assert.svh =====
// assertion macros for the imu angle frame parser
// used by the core module; needs nothing else
`ifndef IMU_ANGLE_FRAME_PARSER_CORE_ASSERT_SVH
`define IMU_ANGLE_FRAME_PARSER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define AFP_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("imu frame parser: implication check failed");

// next-cycle implication, checked outside reset
`define AFP_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("imu frame parser: next-cycle check failed");

`endif

// ===== hdl/imu_afp_pkg.sv =====
// shared types, constants and helpers for the imu angle frame parser
// no dependencies
`timescale 1ns / 1ps

package imu_afp_pkg;

  // frame layout
  localparam logic [7:0] HDR_FIRST  = 8'h55;
  localparam logic [7:0] HDR_SECOND = 8'h53;
  localparam int unsigned FRAME_LEN = 9;
  localparam int unsigned ANGLE_BYTES = 6;
  localparam int unsigned ANGLE_W = 17;

  // checksum starts from both header bytes
  localparam logic [7:0] HDR_SUM = HDR_FIRST + HDR_SECOND;

  // raw words above a half turn wrap to negative
  localparam logic [15:0] HALF_TURN = 16'h8000;

  typedef logic signed [ANGLE_W-1:0] angle_t;

  typedef enum logic [1:0] {
    PH_HDR1,
    PH_HDR2,
    PH_DATA
  } phase_t;

  // low/high byte pair to a 17-bit angle code (r or r - 65536)
  function automatic angle_t word_to_angle(logic [7:0] lo, logic [7:0] hi);
    logic [15:0] raw;
    raw = {hi, lo};
    return $signed({(raw > HALF_TURN), raw});
  endfunction

endpackage

// ===== hdl/imu_angle_frame_parser_core.sv =====
// imu angle frame parser: header hunt, byte collection, checksum, angle hold
// depends on imu_afp_pkg and imu_angle_frame_parser_core_assert.svh
//
//   channel | dir | payload                                         | handshake
//   in      | in  | in_rx_byte                                      | in_valid/in_ready
//   out     | out | out_checksum_ok, out_roll/pitch/yaw_angle       | out_valid/out_ready
//
// one byte per cycle while in_ready is high; the result of a frame is registered
// at its checksum byte transfer and shows in the cycle after that transfer
// in_ready drops only when the checksum byte is next and the result register
// still holds an untaken result
// reset (rst_n low, synchronous) returns to the first-header hunt, clears the
// held angles and the result valid
`timescale 1ns / 1ps
`include "imu_angle_frame_parser_core_assert.svh"

module imu_angle_frame_parser_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_checksum_ok,
  output logic signed [16:0]         out_roll_angle,
  output logic signed [16:0]         out_pitch_angle,
  output logic signed [16:0]         out_yaw_angle
);

  localparam logic [3:0] LAST_IDX  = 4'(imu_afp_pkg::FRAME_LEN - 1);
  localparam logic [3:0] ANGLE_END = 4'(imu_afp_pkg::ANGLE_BYTES);

  imu_afp_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]          count_r, count_nxt;
  logic [7:0]          sum_r, sum_nxt;
  logic [7:0]          frame_r [imu_afp_pkg::ANGLE_BYTES];
  imu_afp_pkg::angle_t held_roll_r, held_pitch_r, held_yaw_r;
  imu_afp_pkg::angle_t held_roll_nxt, held_pitch_nxt, held_yaw_nxt;

  logic                out_valid_r;
  logic                out_ok_r;
  imu_afp_pkg::angle_t out_roll_r, out_pitch_r, out_yaw_r;

  logic last_byte;
  logic in_fire;
  logic emit;
  logic sum_ok;

  // checksum byte is next in the frame
  assign last_byte = (phase_r == imu_afp_pkg::PH_DATA) && (count_r == LAST_IDX);
  assign in_ready  = !last_byte || !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign emit      = in_fire && last_byte;
  assign sum_ok    = (sum_r == in_rx_byte);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      case (phase_r)
        imu_afp_pkg::PH_HDR1: begin
          phase_nxt = (in_rx_byte == imu_afp_pkg::HDR_FIRST) ? imu_afp_pkg::PH_HDR2
                                                               : imu_afp_pkg::PH_HDR1;
        end
        imu_afp_pkg::PH_HDR2: begin
          phase_nxt = (in_rx_byte == imu_afp_pkg::HDR_SECOND) ? imu_afp_pkg::PH_DATA
                                                                : imu_afp_pkg::PH_HDR1;
        end
        imu_afp_pkg::PH_DATA: begin
          if (last_byte) begin
            phase_nxt = imu_afp_pkg::PH_HDR1;
          end
        end
        default: begin
          phase_nxt = (in_rx_byte == imu_afp_pkg::HDR_FIRST) ? imu_afp_pkg::PH_HDR2
                                                               : imu_afp_pkg::PH_HDR1;
        end
      endcase
    end
  end

  // byte count, running checksum and held angles
  always_comb begin
    count_nxt      = count_r;
    sum_nxt        = sum_r;
    held_roll_nxt  = held_roll_r;
    held_pitch_nxt = held_pitch_r;
    held_yaw_nxt   = held_yaw_r;
    if (in_fire) begin
      case (phase_r)
        imu_afp_pkg::PH_HDR2: begin
          count_nxt = '0;
          sum_nxt   = imu_afp_pkg::HDR_SUM;
        end
        imu_afp_pkg::PH_DATA: begin
          if (last_byte) begin
            if (sum_ok) begin
              held_roll_nxt  = imu_afp_pkg::word_to_angle(frame_r[0], frame_r[1]);
              held_pitch_nxt = imu_afp_pkg::word_to_angle(frame_r[2], frame_r[3]);
              held_yaw_nxt   = imu_afp_pkg::word_to_angle(frame_r[4], frame_r[5]);
            end
          end else begin
            count_nxt = count_r + 4'd1;
            sum_nxt   = sum_r + in_rx_byte;
          end
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= imu_afp_pkg::PH_HDR1;
      count_r      <= '0;
      held_roll_r  <= '0;
      held_pitch_r <= '0;
      held_yaw_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      count_r      <= count_nxt;
      held_roll_r  <= held_roll_nxt;
      held_pitch_r <= held_pitch_nxt;
      held_yaw_r   <= held_yaw_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // checksum accumulator and angle bytes of the frame
  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    if (in_fire && (phase_r == imu_afp_pkg::PH_DATA) && (count_r < ANGLE_END)) begin
      frame_r[count_r[2:0]] <= in_rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_ok_r    <= sum_ok;
      out_roll_r  <= held_roll_nxt;
      out_pitch_r <= held_pitch_nxt;
      out_yaw_r   <= held_yaw_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_checksum_ok = out_ok_r;
  assign out_roll_angle  = out_roll_r;
  assign out_pitch_angle = out_pitch_r;
  assign out_yaw_angle   = out_yaw_r;

  // checks
  `AFP_ASSERT_IMPLY(a_count_range, clk, rst_n, 1'b1, count_r <= LAST_IDX)
  `AFP_ASSERT_IMPLY(a_stall_on_full, clk, rst_n, last_byte && out_valid_r && !out_ready, !in_ready)
  `AFP_ASSERT_NEXT(a_emit_shows, clk, rst_n, emit, out_valid_r)
  `AFP_ASSERT_NEXT(a_hold_no_emit, clk, rst_n, !emit, $stable(held_roll_r) && $stable(held_yaw_r))
  `AFP_ASSERT_IMPLY(a_out_matches_held, clk, rst_n, out_valid_r, out_roll_r == held_roll_r && out_pitch_r == held_pitch_r)

endmodule

// ===== sim/imu_angle_frame_parser_checker.sv =====
// result checker for the imu angle frame parser: tracks byte transfers,
// predicts frame results and compares them with the result channel
// depends on imu_afp_pkg
`timescale 1ns / 1ps

module imu_angle_frame_parser_checker
  import imu_afp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_checksum_ok,
  input  angle_t     out_roll_angle,
  input  angle_t     out_pitch_angle,
  input  angle_t     out_yaw_angle,
  output int         fail_count,
  output int         outstanding,
  output int         good_frames,
  output int         bad_frames
);

  typedef struct packed {
    logic   ok;
    angle_t roll;
    angle_t pitch;
    angle_t yaw;
  } frame_result_t;

  // predicted parser state
  phase_t        phase;
  logic [3:0]    byte_idx;
  logic [7:0]    frame_buf [FRAME_LEN];
  angle_t        roll_hold;
  angle_t        pitch_hold;
  angle_t        yaw_hold;
  frame_result_t frame_results_q[$];
  int            errors = 0;
  int            n_good = 0;
  int            n_bad  = 0;

  // raw sensor word to signed angle code; words above a half turn wrap negative
  function automatic angle_t sensor_word_angle(input logic [15:0] w);
    if (w > 16'd32768) return angle_t'(int'(w) - 65536);
    return angle_t'(int'(w));
  endfunction

  // advance the predicted parser by one byte transfer
  task automatic track_byte(input logic [7:0] b);
    logic [7:0]    sum;
    frame_result_t res;
    case (phase)
      PH_HDR2: begin
        if (b == HDR_SECOND) begin
          phase    = PH_DATA;
          byte_idx = '0;
        end else begin
          phase = PH_HDR1;
        end
      end
      PH_DATA: begin
        frame_buf[byte_idx] = b;
        byte_idx = byte_idx + 1'b1;
        if (byte_idx == FRAME_LEN) begin
          // checksum covers both headers and the eight data bytes
          sum = HDR_FIRST + HDR_SECOND;
          for (int i = 0; i < 8; i++) sum = sum + frame_buf[i];
          res.ok = (sum == frame_buf[8]);
          if (res.ok) begin
            roll_hold  = sensor_word_angle({frame_buf[1], frame_buf[0]});
            pitch_hold = sensor_word_angle({frame_buf[3], frame_buf[2]});
            yaw_hold   = sensor_word_angle({frame_buf[5], frame_buf[4]});
          end
          res.roll  = roll_hold;
          res.pitch = pitch_hold;
          res.yaw   = yaw_hold;
          frame_results_q.push_back(res);
          phase = PH_HDR1;
        end
      end
      default: phase = (b == HDR_FIRST) ? PH_HDR2 : PH_HDR1;
    endcase
  endtask

  // watch both channels; results are compared before the byte of the same edge
  always @(posedge clk) begin
    frame_result_t exp_res;
    if (!rst_n) begin
      phase      = PH_HDR1;
      byte_idx   = '0;
      roll_hold  = '0;
      pitch_hold = '0;
      yaw_hold   = '0;
      frame_results_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (frame_results_q.size() == 0) begin
          $error("result transfer with no frame result expected");
          errors++;
        end else begin
          exp_res = frame_results_q.pop_front();
          if (exp_res.ok) n_good++;
          else n_bad++;
          if (out_checksum_ok !== exp_res.ok) begin
            $error("checksum_ok: expected %0d, got %0d", exp_res.ok, out_checksum_ok);
            errors++;
          end
          if (out_roll_angle !== exp_res.roll) begin
            $error("roll_angle: expected %0d, got %0d", exp_res.roll, out_roll_angle);
            errors++;
          end
          if (out_pitch_angle !== exp_res.pitch) begin
            $error("pitch_angle: expected %0d, got %0d", exp_res.pitch, out_pitch_angle);
            errors++;
          end
          if (out_yaw_angle !== exp_res.yaw) begin
            $error("yaw_angle: expected %0d, got %0d", exp_res.yaw, out_yaw_angle);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) track_byte(in_rx_byte);
    end
    fail_count  <= errors;
    outstanding <= frame_results_q.size();
    good_frames <= n_good;
    bad_frames  <= n_bad;
  end

endmodule

// ===== sim/tb_imu_angle_frame_parser_core.sv =====
// testbench top for the imu angle frame parser: byte stimulus, result-side
// stalls and the final verdict
// depends on imu_afp_pkg, imu_angle_frame_parser_core and the frame checker
`timescale 1ns / 1ps

module tb_imu_angle_frame_parser_core;
  import imu_afp_pkg::*;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_ready  = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       out_checksum_ok;
  angle_t     out_roll_angle;
  angle_t     out_pitch_angle;
  angle_t     out_yaw_angle;

  int fail_count;
  int outstanding;
  int good_frames;
  int bad_frames;

  // sender burst state
  int burst_left = 0;
  int items_sent = 0;
  int frames_sent = 0;

  // receiver stall state
  int ready_mode = 0;
  int mode_left  = 0;
  int stall_left = 0;
  int cyc        = 0;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  imu_angle_frame_parser_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_checksum_ok (out_checksum_ok),
    .out_roll_angle  (out_roll_angle),
    .out_pitch_angle (out_pitch_angle),
    .out_yaw_angle   (out_yaw_angle)
  );

  imu_angle_frame_parser_checker frame_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_checksum_ok (out_checksum_ok),
    .out_roll_angle  (out_roll_angle),
    .out_pitch_angle (out_pitch_angle),
    .out_yaw_angle   (out_yaw_angle),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .good_frames     (good_frames),
    .bad_frames      (bad_frames)
  );

  // result-side stall pattern: always ready, coin flip, one in four, long stalls
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (mode_left == 0) begin
      mode_left  <= $urandom_range(32, 400);
      ready_mode <= $urandom_range(0, 3);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (cyc[1:0] == 2'd0);
      default: begin
        if (stall_left == 0) begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(5, 30);
        end else begin
          out_ready  <= 1'b0;
          stall_left <= stall_left - 1;
        end
      end
    endcase
  end

  // one byte transfer, with a random gap at the start of each burst
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: gap = $urandom_range(0, 2);
        6, 7, 8:          gap = $urandom_range(3, 10);
        default:          gap = $urandom_range(20, 40);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
  endtask

  // header pair, eight data bytes and a checksum, optionally spoiled
  task automatic send_frame(input logic [15:0] roll_w, input logic [15:0] pitch_w,
                            input logic [15:0] yaw_w, input logic [15:0] spare_w,
                            input bit corrupt);
    logic [7:0] data [8];
    logic [7:0] sum;
    data = '{roll_w[7:0], roll_w[15:8], pitch_w[7:0], pitch_w[15:8],
             yaw_w[7:0], yaw_w[15:8], spare_w[7:0], spare_w[15:8]};
    sum = HDR_SUM;
    for (int i = 0; i < 8; i++) sum = sum + data[i];
    if (corrupt) sum = sum + 8'($urandom_range(1, 255));
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    for (int i = 0; i < 8; i++) send_byte(data[i]);
    send_byte(sum);
    frames_sent++;
  endtask

  // hold off the sender until every frame result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // angle words weighted toward the wrap boundary and the extremes
  function automatic logic [15:0] angle_word();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h8001;
      2:       return 16'h7FFF;
      3:       return 16'hFFFF;
      4:       return 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    logic [7:0] b;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes, bad second header (0x55 and other), wrap points
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_FIRST);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(HDR_FIRST);
    send_byte(8'h12);
    send_frame(16'h8000, 16'h8001, 16'hFFFF, 16'h1234, 1'b0);
    // checksum mismatch keeps the held angles
    send_frame(16'h7FFF, 16'h0000, 16'h0001, 16'hABCD, 1'b1);
    drain_results();

    // random: mostly well-formed frames, some broken header pairs and noise
    while (items_sent < 1850) begin
      case ($urandom_range(0, 9))
        0: begin
          send_byte(HDR_FIRST);
          b = ($urandom_range(0, 1) == 1) ? HDR_FIRST : 8'($urandom_range(0, 255));
          if (b == HDR_SECOND) b = 8'h00;
          send_byte(b);
        end
        1: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        default: begin
          send_frame(angle_word(), angle_word(), angle_word(),
                     16'($urandom_range(0, 65535)), $urandom_range(0, 3) == 0);
          if (frames_sent % 40 == 0) drain_results();
        end
      endcase
    end
    in_valid <= 1'b0;

    // wait for the last results, then a few more cycles
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("run: %0d byte transfers, %0d frames sent", items_sent, frames_sent);
    $display("results: %0d with good checksum, %0d with bad checksum",
             good_frames, bad_frames);
    if (fail_count == 0 && outstanding == 0) begin
      $display("imu_angle_frame_parser_core regression: pass");
    end else begin
      $display("imu_angle_frame_parser_core regression: fail");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #20000000;
    $display("timeout waiting for transfers");
    $display("imu_angle_frame_parser_core regression: fail");
    $finish;
  end

endmodule
